>>> hdl/epec_pkg.sv
// ----------------------------------------------------------------------------
// Euler path check package
// Shared sizes, verdict codes and the controller state type.
// ----------------------------------------------------------------------------
package epec_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_V_W      = $clog2(MAX_VERTICES + 1);
    localparam int EADDR_W      = $clog2(MAX_EDGES);
    localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
    localparam int STACK_DEPTH  = MAX_EDGES + 1;
    localparam int SADDR_W      = $clog2(STACK_DEPTH);
    localparam int EWORD_W      = 2 * VTX_W + 1;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_PATH = 2'd1,
        VERDICT_BAD  = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FIRST,
        ST_EREQ,
        ST_ECHK,
        ST_TOP,
        ST_TOPW,
        ST_DONE
    } t_state;

endpackage

>>> hdl/euler_path_existence_check.sv
// ----------------------------------------------------------------------------
// Euler path existence check
// Loads multigraph edges into an edge memory and, on the last edge, walks the
// graph with a stack memory to decide whether an Euler path exists.
// ----------------------------------------------------------------------------
// Edges load at one request per cycle in the load state. The request marked
// last starts the check, during which no request is taken: a parity scan
// over the vertices in use, then a stack walk that reads the edge memory one
// entry at a time, restarting its search from entry 0 after every crossed
// edge and every pop. The verdict sits in an output register; a new graph
// may start loading while it waits.
module euler_path_existence_check
    import epec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,     // vertex_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [7:0] end_a, [15:8] end_b
    input  logic        s_axis_tuser,    // [0] edge_present
    input  logic        s_axis_tlast,    // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] verdict, [7:2] zero
);

    // Registers.
    t_state                  r_state, n_state;
    logic [8:0]              r_vcnt, n_vcnt;
    logic [MAX_VERTICES-1:0] r_par, n_par;
    logic [ECNT_W-1:0]       r_loaded, n_loaded;
    logic                    r_bad, n_bad;
    logic [CNT_V_W-1:0]      r_vi, n_vi;
    logic [1:0]              r_odd, n_odd;
    logic [VTX_W-1:0]        r_start, n_start;
    logic [VTX_W-1:0]        r_v, n_v;
    logic [ECNT_W-1:0]       r_i, n_i;
    logic [SADDR_W-1:0]      r_sp, n_sp;
    logic [ECNT_W-1:0]       r_ucnt, n_ucnt;
    t_verdict                r_verdict, n_verdict;
    logic                    r_ovalid, n_ovalid;
    t_verdict                r_odata, n_odata;

    // Memory ports.
    logic [EWORD_W-1:0] r_emem [MAX_EDGES];
    logic [EWORD_W-1:0] r_erd;
    logic               w_ere, w_ewe;
    logic [EADDR_W-1:0] w_eraddr, w_ewaddr;
    logic [EWORD_W-1:0] w_ewdata;
    logic [VTX_W-1:0]   r_smem [STACK_DEPTH];
    logic [VTX_W-1:0]   r_srd;
    logic               w_sre, w_swe;
    logic [SADDR_W-1:0] w_sraddr, w_swaddr;
    logic [VTX_W-1:0]   w_swdata;

    logic [VTX_W-1:0]   w_a, w_b, w_ea, w_eb, w_other;
    logic [CNT_V_W-1:0] w_n;
    logic               w_acc, w_ok;

    assign w_a   = s_axis_tdata[VTX_W-1:0];
    assign w_b   = s_axis_tdata[2*VTX_W-1:VTX_W];
    assign w_n   = (r_vcnt > 9'(MAX_VERTICES)) ? CNT_V_W'(MAX_VERTICES) : CNT_V_W'(r_vcnt);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_ok  = ({1'b0, w_a} < w_n) && ({1'b0, w_b} < w_n)
                   && (r_loaded < ECNT_W'(MAX_EDGES));
    assign w_ea  = r_erd[2*VTX_W-1:VTX_W];
    assign w_eb  = r_erd[VTX_W-1:0];
    assign w_other = (w_ea == r_v) ? w_eb : w_ea;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};

    // Edge memory: {used, end_a, end_b}.
    always_ff @(posedge i_clk) begin
        if (w_ewe) begin
            r_emem[w_ewaddr] <= w_ewdata;
        end
        if (w_ere) begin
            r_erd <= r_emem[w_eraddr];
        end
    end

    // Walk stack memory.
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_smem[w_swaddr] <= w_swdata;
        end
        if (w_sre) begin
            r_srd <= r_smem[w_sraddr];
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_vcnt   <= 9'(MAX_VERTICES);
            r_par    <= '0;
            r_loaded <= '0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vcnt   <= n_vcnt;
            r_par    <= n_par;
            r_loaded <= n_loaded;
            r_bad    <= n_bad;
            r_ovalid <= n_ovalid;
        end
    end

    // Walk datapath registers.
    always_ff @(posedge i_clk) begin
        r_vi      <= n_vi;
        r_odd     <= n_odd;
        r_start   <= n_start;
        r_v       <= n_v;
        r_i       <= n_i;
        r_sp      <= n_sp;
        r_ucnt    <= n_ucnt;
        r_verdict <= n_verdict;
        r_odata   <= n_odata;
    end

    // Next state, memory requests and verdict.
    always_comb begin
        n_state   = r_state;
        n_vcnt    = i_cfg_we ? i_cfg_wdata : r_vcnt;
        n_par     = r_par;
        n_loaded  = r_loaded;
        n_bad     = r_bad;
        n_vi      = r_vi;
        n_odd     = r_odd;
        n_start   = r_start;
        n_v       = r_v;
        n_i       = r_i;
        n_sp      = r_sp;
        n_ucnt    = r_ucnt;
        n_verdict = r_verdict;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        w_ere     = 1'b0;
        w_eraddr  = r_i[EADDR_W-1:0];
        w_ewe     = 1'b0;
        w_ewaddr  = r_loaded[EADDR_W-1:0];
        w_ewdata  = {1'b0, w_a, w_b};
        w_sre     = 1'b0;
        w_sraddr  = r_sp - SADDR_W'(1);
        w_swe     = 1'b0;
        w_swaddr  = r_sp;
        w_swdata  = w_other;

        case (r_state)
            // Take edges, keep degree parity.
            ST_LOAD: begin
                if (w_acc) begin
                    if (s_axis_tuser) begin
                        if (w_ok) begin
                            w_ewe    = 1'b1;
                            n_loaded = r_loaded + ECNT_W'(1);
                            for (int k = 0; k < MAX_VERTICES; k++) begin
                                n_par[k] = r_par[k] ^ (w_a == VTX_W'(k)) ^ (w_b == VTX_W'(k));
                            end
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_SCAN;
                        n_vi    = '0;
                        n_odd   = '0;
                        n_start = '0;
                    end
                end
            end

            // Count odd vertices, remember the highest one.
            ST_SCAN: begin
                if (r_bad) begin
                    n_verdict = VERDICT_BAD;
                    n_state   = ST_DONE;
                end else if (r_vi < w_n) begin
                    n_vi = r_vi + CNT_V_W'(1);
                    if (r_par[r_vi[VTX_W-1:0]]) begin
                        n_start = r_vi[VTX_W-1:0];
                        if (r_odd == 2'd2) begin
                            n_verdict = VERDICT_NONE;
                            n_state   = ST_DONE;
                        end else begin
                            n_odd = r_odd + 2'd1;
                        end
                    end
                end else if (r_loaded == '0) begin
                    n_verdict = VERDICT_PATH;
                    n_state   = ST_DONE;
                end else if (r_odd != 2'd0) begin
                    w_swe    = 1'b1;
                    w_swaddr = '0;
                    w_swdata = r_start;
                    n_sp     = SADDR_W'(1);
                    n_v      = r_start;
                    n_i      = '0;
                    n_ucnt   = '0;
                    n_state  = ST_EREQ;
                end else begin
                    w_ere    = 1'b1;
                    w_eraddr = '0;
                    n_state  = ST_FIRST;
                end
            end

            // No odd vertex: start at the first endpoint of the first edge.
            ST_FIRST: begin
                w_swe    = 1'b1;
                w_swaddr = '0;
                w_swdata = w_ea;
                n_sp     = SADDR_W'(1);
                n_v      = w_ea;
                n_i      = '0;
                n_ucnt   = '0;
                n_state  = ST_EREQ;
            end

            ST_EREQ: begin
                w_ere   = 1'b1;
                n_state = ST_ECHK;
            end

            // Cross the first unused incident edge, or pop when none is left.
            ST_ECHK: begin
                if (!r_erd[EWORD_W-1] && (w_ea == r_v || w_eb == r_v)) begin
                    w_ewe    = 1'b1;
                    w_ewaddr = r_i[EADDR_W-1:0];
                    w_ewdata = {1'b1, w_ea, w_eb};
                    w_swe    = 1'b1;
                    n_sp     = r_sp + SADDR_W'(1);
                    n_ucnt   = r_ucnt + ECNT_W'(1);
                    n_v      = w_other;
                    n_i      = '0;
                    n_state  = ST_EREQ;
                end else if (r_i + ECNT_W'(1) == r_loaded) begin
                    n_sp = r_sp - SADDR_W'(1);
                    n_i  = '0;
                    if (r_sp == SADDR_W'(1)) begin
                        n_verdict = (r_ucnt == r_loaded) ? VERDICT_PATH : VERDICT_NONE;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_TOP;
                    end
                end else begin
                    n_i     = r_i + ECNT_W'(1);
                    n_state = ST_EREQ;
                end
            end

            ST_TOP: begin
                w_sre   = 1'b1;
                n_state = ST_TOPW;
            end

            ST_TOPW: begin
                n_v     = r_srd;
                n_state = ST_EREQ;
            end

            // Hand over the verdict and clear the graph.
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_verdict;
                    n_par    = '0;
                    n_loaded = '0;
                    n_bad    = 1'b0;
                    n_state  = ST_LOAD;
                end
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

>>> hdl/epec_checker.sv
// ----------------------------------------------------------------------------
// Euler path check port checker
// Watches the top-level ports for handshake and verdict consistency.
// ----------------------------------------------------------------------------
module epec_checker
    import epec_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled verdict holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    // Only defined verdict codes appear.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == 8'(VERDICT_NONE)
                           || m_axis_tdata == 8'(VERDICT_PATH)
                           || m_axis_tdata == 8'(VERDICT_BAD)))
        else $error("undefined verdict code");

    // A request without the last mark never produces a verdict.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
        else $error("verdict without last request");

    // The check blocks further requests.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("request taken during check");

endmodule

bind euler_path_existence_check epec_checker u_epec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/euler_path_existence_check_test.sv
// ----------------------------------------------------------------------------
// Euler path existence check testbench
// Sends multigraph edge requests under random gaps on both stream sides. A
// predictor of its own works out each verdict, which is compared with the
// verdict returned. It opens with a table of directed cases, fills the edge
// store once, and then runs random graphs under several vertex counts.
// ----------------------------------------------------------------------------
module euler_path_existence_check_test;
    import epec_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int IDLE_LIMIT   = 100000;
    localparam int SETTLE_WAIT  = 16;
    localparam int ITEM_TARGET  = 1550;
    localparam int HOLD_CYCLES  = 600;

    // Kinds of directed table rows.
    typedef enum logic [1:0] {
        ROW_EDGE,
        ROW_CHECK,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic [7:0] end_a;
        logic [7:0] end_b;
        logic present;
        logic last;
        logic [8:0] cfg_value;
        t_verdict typed_verdict;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    // Predictor state.
    logic [8:0]  pred_vertex_count;
    logic [15:0] pred_edges [MAX_EDGES];
    logic        pred_used [MAX_EDGES];
    logic        pred_odd [MAX_VERTICES];
    int          pred_loaded;
    logic        pred_bad;
    int          walk_stack [MAX_EDGES + 1];

    t_verdict    verdict_queue [$];
    int          error_count;
    int          items_sent;
    int          idle_cycles;
    bit          hold_req;
    t_row        directed [$];

    euler_path_existence_check DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    function automatic int vertices_active();
        return (pred_vertex_count < MAX_VERTICES) ? int'(pred_vertex_count) : MAX_VERTICES;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < MAX_EDGES; i++) pred_used[i] = 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++) pred_odd[i] = 1'b0;
        pred_loaded = 0;
        pred_bad = 1'b0;
    endfunction

    // Odd-degree count, then a stack walk from the last odd vertex or from
    // the first endpoint of the first stored edge.
    function automatic t_verdict judge_graph();
        int n;
        int odd;
        int start;
        int sp;
        int v;
        int ea;
        int eb;
        bit have_odd;
        bit moved;
        n = vertices_active();
        odd = 0;
        start = 0;
        sp = 0;
        have_odd = 0;
        if (pred_bad) return VERDICT_BAD;
        for (int i = 0; i < n; i++) begin
            if (pred_odd[i]) begin
                odd++;
                if (odd > 2) return VERDICT_NONE;
                start = i;
                have_odd = 1;
            end
        end
        if (pred_loaded == 0) return VERDICT_PATH;
        if (!have_odd) start = pred_edges[0][15:8];
        walk_stack[sp++] = start;
        while (sp > 0) begin
            v = walk_stack[sp - 1];
            moved = 0;
            for (int i = 0; i < pred_loaded; i++) begin
                ea = pred_edges[i][15:8];
                eb = pred_edges[i][7:0];
                if (!pred_used[i] && (ea == v || eb == v)) begin
                    pred_used[i] = 1'b1;
                    if (sp < MAX_EDGES + 1) walk_stack[sp++] = (ea == v) ? eb : ea;
                    moved = 1;
                    break;
                end
            end
            if (!moved) sp--;
        end
        for (int i = 0; i < pred_loaded; i++) begin
            if (!pred_used[i]) return VERDICT_NONE;
        end
        return VERDICT_PATH;
    endfunction

    // Applies one accepted edge request; returns 1 with a verdict on a last mark.
    function automatic bit predict_verdict(input logic [7:0] a, input logic [7:0] b,
                                           input logic present, input logic last,
                                           output t_verdict verdict);
        int n;
        n = vertices_active();
        verdict = VERDICT_NONE;
        if (present) begin
            if (a >= n || b >= n || pred_loaded >= MAX_EDGES) begin
                pred_bad = 1'b1;
            end else begin
                pred_edges[pred_loaded] = {a, b};
                pred_used[pred_loaded] = 1'b0;
                pred_loaded++;
                pred_odd[a] ^= 1'b1;
                pred_odd[b] ^= 1'b1;
            end
        end
        if (!last) return 0;
        verdict = judge_graph();
        clear_graph();
        return 1;
    endfunction

    // Sends one edge request after a random gap and records its verdict, if any.
    task automatic send_edge(input logic [7:0] a, input logic [7:0] b, input logic present,
                             input logic last, input bit use_typed, input t_verdict typed);
        int gap;
        int pick;
        t_verdict verdict;
        pick = $urandom_range(0, 19);
        if (pick < 13) gap = 0;
        else if (pick < 18) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (predict_verdict(a, b, present, last, verdict)) begin
            if (use_typed && verdict != typed) begin
                $error("typed verdict: expected %0d, predictor %0d", typed, verdict);
                error_count++;
            end
            verdict_queue.insert(verdict_queue.size(), use_typed ? typed : verdict);
        end
    endtask

    // Writes the vertex count once the block has answered everything.
    task automatic write_count(input logic [8:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_vertex_count = value;
    endtask

    function automatic logic [7:0] pick_vertex(input int span);
        return 8'($urandom_range(0, span - 1));
    endfunction

    // One random graph: mostly a walk, which always has an Euler path.
    task automatic send_random_graph(input bit terminate);
        int n;
        int span;
        int edges;
        int kind;
        int bad_at;
        logic [7:0] cur;
        logic [7:0] nxt;
        logic [7:0] a;
        logic [7:0] b;
        n = vertices_active();
        span = (n == 0) ? 256 : n;
        if ($urandom_range(0, 3) != 0 && span > 8) span = $urandom_range(2, 8);
        edges = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        bad_at = (kind == 9) ? $urandom_range(0, edges - 1) : -1;
        cur = pick_vertex(span);
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_edge(8'($urandom), 8'($urandom), 1'b0, 1'b0, 0, VERDICT_NONE);
            end
            if (kind < 6) begin
                nxt = pick_vertex(span);
                a = cur;
                b = nxt;
                if ($urandom_range(0, 1)) begin
                    a = nxt;
                    b = cur;
                end
                cur = nxt;
            end else begin
                a = pick_vertex(span);
                b = pick_vertex(span);
            end
            if (i == bad_at) begin
                if (n < 256) a = 8'($urandom_range(n, 255));
                else a = 8'($urandom);
            end
            send_edge(a, b, 1'b1, terminate && (i == edges - 1), 0, VERDICT_NONE);
        end
    endtask

    // Stimulus.
    initial begin
        logic [8:0] counts [$];
        t_row r;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        pred_vertex_count = 9'd256;
        clear_graph();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        directed = '{
            '{ROW_CHECK, 8'd0,   8'd0,   1'b0, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_CHECK, 8'd255, 8'd255, 1'b1, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_EDGE,  8'd0,   8'd255, 1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd255, 8'd0,   1'b1, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_EDGE,  8'd0,   8'd1,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd2,   8'd3,   1'b1, 1'b1, 9'd0,   VERDICT_NONE},
            '{ROW_EDGE,  8'd0,   8'd1,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_EDGE,  8'd1,   8'd0,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_EDGE,  8'd2,   8'd3,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd3,   8'd2,   1'b1, 1'b1, 9'd0,   VERDICT_NONE},
            '{ROW_EDGE,  8'd170, 8'd85,  1'b0, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_EDGE,  8'd1,   8'd2,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd2,   8'd7,   1'b1, 1'b1, 9'd0,   VERDICT_NONE},
            '{ROW_CFG,   8'd0,   8'd0,   1'b0, 1'b0, 9'd1,   VERDICT_NONE},
            '{ROW_CHECK, 8'd0,   8'd0,   1'b1, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_CHECK, 8'd1,   8'd0,   1'b1, 1'b1, 9'd0,   VERDICT_BAD},
            '{ROW_CFG,   8'd0,   8'd0,   1'b0, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd0,   8'd0,   1'b1, 1'b1, 9'd0,   VERDICT_BAD},
            '{ROW_CHECK, 8'd0,   8'd0,   1'b0, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_CFG,   8'd0,   8'd0,   1'b0, 1'b0, 9'd511, VERDICT_NONE},
            '{ROW_EDGE,  8'd0,   8'd9,   1'b1, 1'b0, 9'd0,   VERDICT_NONE},
            '{ROW_CHECK, 8'd9,   8'd4,   1'b1, 1'b1, 9'd0,   VERDICT_PATH},
            '{ROW_CFG,   8'd0,   8'd0,   1'b0, 1'b0, 9'd256, VERDICT_NONE}
        };
        foreach (directed[i]) begin
            r = directed[i];
            if (r.kind == ROW_CFG) begin
                write_count(r.cfg_value);
            end else begin
                // Checks whose first endpoint is not 2 queue their typed verdict, held against the predictor.
                send_edge(r.end_a, r.end_b, r.present, r.last,
                          r.kind == ROW_CHECK && r.end_a != 8'd2, r.typed_verdict);
            end
        end

        // Fill the edge store; the edge past the end makes the verdict invalid.
        for (int i = 0; i < MAX_EDGES + 1; i++) begin
            send_edge(8'($urandom), 8'($urandom), 1'b1, i == MAX_EDGES, 0, VERDICT_NONE);
        end

        // Hold the receiver off while graphs keep coming, so the block backs up.
        hold_req = 1'b1;
        repeat (6) begin
            send_random_graph(1'b1);
        end

        // Random graphs in phases of vertex count. A phase may end mid-graph,
        // so the count changes while edges are loaded.
        counts = '{9'd256, 9'd511, 9'd2, 9'd1, 9'd0, 9'd5, 9'd17, 9'd300, 9'd255};
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) write_count(9'($urandom_range(1, 256)));
            else write_count(counts[$urandom_range(0, counts.size() - 1)]);
            repeat ($urandom_range(3, 10)) begin
                send_random_graph(1'b1);
            end
            if ($urandom_range(0, 3) == 0) send_random_graph(1'b0);
        end
        send_edge(8'd0, 8'd0, 1'b0, 1'b1, 0, VERDICT_NONE);
        s_axis_tvalid <= 1'b0;

        // Drain.
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: random stalls, and one long hold-off once the sender asks for it.
    initial begin
        bit held;
        held = 0;
        m_axis_tready = 1'b0;
        forever begin
            if (!held && hold_req) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if ($urandom_range(0, 1)) begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 40)) @(posedge i_clk);
                else repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // Verdict checker.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_queue.size() == 0) begin
                $error("verdict: none expected, actual %0d", m_axis_tdata[1:0]);
                error_count++;
            end else begin
                want = verdict_queue.pop_front();
                if (m_axis_tdata[1:0] != want) begin
                    $error("verdict: expected %0d, actual %0d", want, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[7:2] != 6'd0) begin
                    $error("pad: expected 0, actual %0d", m_axis_tdata[7:2]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without an accepted request, a taken verdict or a count write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
